>>> hdl/obm_pkg.sv
// shared types and codes for the order book matcher
package obm_pkg;

    typedef struct packed {
        logic [31:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [15:0] trader;
        logic [31:0] arrival;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;

    localparam logic TYPE_LIMIT  = 1'b0;
    localparam logic TYPE_MARKET = 1'b1;

    localparam logic [1:0] TIF_GTC = 2'd0;
    localparam logic [1:0] TIF_FOK = 2'd2;

    localparam logic [2:0] STP_CANCEL_NEW  = 3'd1;
    localparam logic [2:0] STP_CANCEL_OLD  = 3'd2;
    localparam logic [2:0] STP_CANCEL_BOTH = 3'd3;
    localparam logic [2:0] STP_SKIP_OWN    = 3'd4;

    localparam logic [1:0] KIND_TRADE    = 2'd0;
    localparam logic [1:0] KIND_RESTING  = 2'd1;
    localparam logic [1:0] KIND_INCOMING = 2'd2;
    localparam logic [1:0] KIND_FINAL    = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_DUPLICATE = 4'd1;
    localparam logic [3:0] ST_ZERO_QTY  = 4'd2;
    localparam logic [3:0] ST_NO_PRICE  = 4'd3;
    localparam logic [3:0] ST_MKT_GTC   = 4'd4;
    localparam logic [3:0] ST_FOK_SHORT = 4'd5;
    localparam logic [3:0] ST_NO_LIQ    = 4'd6;
    localparam logic [3:0] ST_NOT_FOUND = 4'd7;
    localparam logic [3:0] ST_FULL      = 4'd8;

endpackage

>>> hdl/order_book_matcher.sv
// price-time priority limit order book with self-trade prevention
// passes: every request makes one or more passes over the slot ram, one slot read per
//   cycle; a cancel or a rejected add takes one pass; an accepted add takes one
//   validation pass, one pass per fill or stp action, then a final pass that finds
//   nothing more, or the final state when the order is used up (the second state and
//   then the final state after a cancel both)
// throughput: one request at a time, busy stays high until the last result is out
// each result is a one-cycle pulse on o_strobe, the receiver cannot stall
// reset (synchronous, active low) clears slot valid bits, arrival counter and fsm
module order_book_matcher
    import obm_pkg::*;
#(
    parameter int ORDER_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic        i_order_type,
    input  logic [1:0]  i_time_in_force,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic [15:0] i_trader_id,
    input  logic [2:0]  i_stp_mode,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_buy_order_id,
    output logic [31:0] o_sell_order_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_quantity,
    output logic [31:0] o_cancelled_order_id,
    output logic [3:0]  o_status,
    output logic [31:0] o_remaining_quantity,
    output logic        o_last
);
    localparam int IW = $clog2(ORDER_SLOTS);
    // liquidity sum of all slots cannot overflow this width
    localparam int AW = 32 + IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ORDER_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SECOND,
        S_FINAL
    } t_state;

    t_state r_state;

    // latched request
    logic        r_op, r_side, r_otype, r_stp_on;
    logic [1:0]  r_tif;
    logic [2:0]  r_stp;
    logic [31:0] r_id, r_price, r_qty, r_rem;
    logic [15:0] r_trader;
    logic [31:0] r_arr_cnt;

    // scan sequencer and what one pass collects
    logic          r_match_phase;
    logic [IW-1:0] r_idx, r_chk_idx, r_best_idx, r_free_idx, r_hit_idx;
    logic          r_issuing, r_chk;
    logic          r_hit, r_any_opp, r_best_found, r_best_own, r_free_found;
    logic [AW-1:0] r_avail;
    logic [31:0]   r_best_age;
    t_slot         r_best;
    logic [ORDER_SLOTS-1:0] r_valid;

    t_slot       rec;
    logic [SLOT_W-1:0] ram_rdata, ram_wdata;
    logic        ram_we;
    logic [IW-1:0] ram_waddr;

    logic        buying, v, is_opp, pok, own, cand, better;
    logic [31:0] age, fill, newq, rem_after;
    logic [3:0]  val_status;
    logic        do_rest;

    assign busy   = (r_state != S_IDLE);
    assign buying = (r_side == SIDE_BUY);

    obm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // per-slot compare on the word just read
    always_comb begin
        rec    = t_slot'(ram_rdata);
        v      = r_valid[r_chk_idx];
        is_opp = (rec.side != r_side);
        pok    = buying ? (rec.price <= r_price) : (rec.price >= r_price);
        own    = r_stp_on && (rec.trader == r_trader);
        cand   = v && is_opp && (r_otype == TYPE_MARKET || pok)
                 && !(own && r_stp == STP_SKIP_OWN);
        age    = r_arr_cnt - rec.arrival;
        better = !r_best_found
                 || (buying ? (rec.price < r_best.price) : (rec.price > r_best.price))
                 || (rec.price == r_best.price && age > r_best_age);
    end

    // fill arithmetic and validation verdict
    always_comb begin
        fill      = (r_rem < r_best.quantity) ? r_rem : r_best.quantity;
        newq      = r_best.quantity - fill;
        rem_after = r_rem - fill;
        if (r_hit) begin
            val_status = ST_DUPLICATE;
        end else if (r_qty == '0) begin
            val_status = ST_ZERO_QTY;
        end else if (r_otype == TYPE_LIMIT && r_price == '0) begin
            val_status = ST_NO_PRICE;
        end else if (r_otype == TYPE_MARKET && r_tif == TIF_GTC) begin
            val_status = ST_MKT_GTC;
        end else if (r_tif == TIF_FOK && r_avail < AW'(r_qty)) begin
            val_status = ST_FOK_SHORT;
        end else if (r_otype == TYPE_MARKET && !r_any_opp) begin
            val_status = ST_NO_LIQ;
        end else begin
            val_status = ST_OK;
        end
        do_rest = (r_rem != '0) && (r_otype == TYPE_LIMIT) && (r_tif == TIF_GTC);
    end

    // ram writes: partial fill write-back, or a new resting order
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        ram_wdata = r_best;
        if (r_state == S_EVAL && r_match_phase) begin
            if (r_best_found && !r_best_own && newq != '0) begin
                ram_we    = 1'b1;
                ram_wdata = t_slot'{r_best.order_id, r_best.side, r_best.price, newq,
                                    r_best.trader, r_best.arrival};
            end else if (!r_best_found && do_rest && r_free_found) begin
                ram_we    = 1'b1;
                ram_waddr = r_free_idx;
                ram_wdata = t_slot'{r_id, r_side, r_price, r_rem, r_trader, r_arr_cnt};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_arr_cnt <= '0;
            r_issuing <= 1'b0;
            r_chk     <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op      <= i_operation;
                        r_id      <= i_order_id;
                        r_side    <= i_side;
                        r_otype   <= i_order_type;
                        r_tif     <= i_time_in_force;
                        r_price   <= i_price;
                        r_qty     <= i_quantity;
                        r_rem     <= i_quantity;
                        r_trader  <= i_trader_id;
                        r_stp     <= i_stp_mode;
                        r_stp_on  <= (i_trader_id != '0) && (i_stp_mode >= STP_CANCEL_NEW)
                                     && (i_stp_mode <= STP_SKIP_OWN);
                        r_match_phase <= 1'b0;
                        r_idx     <= '0;
                        r_issuing <= 1'b1;
                        r_chk     <= 1'b0;
                        r_hit     <= 1'b0;
                        r_any_opp <= 1'b0;
                        r_avail   <= '0;
                        r_best_found <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue side
                    r_chk     <= r_issuing;
                    r_chk_idx <= r_idx;
                    if (r_issuing) begin
                        if (r_idx == LAST_IDX) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    // collect side
                    if (r_chk) begin
                        if (!r_match_phase) begin
                            if (v && rec.order_id == r_id) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_chk_idx;
                            end
                            if (v && is_opp) begin
                                r_any_opp <= 1'b1;
                            end
                            if (v && is_opp && (r_price == '0 || pok)) begin
                                r_avail <= r_avail + AW'(rec.quantity);
                            end
                        end else begin
                            if (cand && better) begin
                                r_best_found <= 1'b1;
                                r_best_own   <= own;
                                r_best_idx   <= r_chk_idx;
                                r_best       <= rec;
                                r_best_age   <= age;
                            end
                            if (!v && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= r_chk_idx;
                            end
                        end
                        if (r_chk_idx == LAST_IDX) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    o_buy_order_id       <= '0;
                    o_sell_order_id      <= '0;
                    o_trade_price        <= '0;
                    o_trade_quantity     <= '0;
                    o_cancelled_order_id <= '0;
                    o_status             <= ST_OK;
                    o_last               <= 1'b0;
                    o_strobe             <= 1'b1;
                    // default: rescan for the next fill
                    r_idx        <= '0;
                    r_issuing    <= 1'b1;
                    r_chk        <= 1'b0;
                    r_best_found <= 1'b0;
                    r_free_found <= 1'b0;
                    r_match_phase <= 1'b1;
                    r_state      <= S_SCAN;
                    if (!r_match_phase) begin
                        if (r_op == OP_CANCEL) begin
                            o_kind   <= KIND_FINAL;
                            o_last   <= 1'b1;
                            o_remaining_quantity <= '0;
                            o_status <= r_hit ? ST_OK : ST_NOT_FOUND;
                            if (r_hit) begin
                                r_valid[r_hit_idx] <= 1'b0;
                            end
                            r_state  <= S_IDLE;
                        end else if (val_status != ST_OK) begin
                            o_kind   <= KIND_FINAL;
                            o_last   <= 1'b1;
                            o_status <= val_status;
                            o_remaining_quantity <= r_qty;
                            r_state  <= S_IDLE;
                        end else begin
                            // validation passed, matching pass starts, nothing shown
                            o_strobe <= 1'b0;
                        end
                    end else if (!r_best_found) begin
                        // nothing more to match against
                        o_kind   <= KIND_FINAL;
                        o_last   <= 1'b1;
                        o_remaining_quantity <= r_rem;
                        if (do_rest) begin
                            if (r_free_found) begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_arr_cnt <= r_arr_cnt + 1'b1;
                            end else begin
                                o_status <= ST_FULL;
                            end
                        end
                        r_state  <= S_IDLE;
                    end else if (r_best_own) begin
                        if (r_stp == STP_CANCEL_OLD) begin
                            o_kind <= KIND_RESTING;
                            o_cancelled_order_id <= r_best.order_id;
                            o_remaining_quantity <= r_rem;
                            r_valid[r_best_idx] <= 1'b0;
                        end else begin
                            // cancel newest or both: incoming goes first
                            o_kind <= KIND_INCOMING;
                            o_cancelled_order_id <= r_id;
                            o_remaining_quantity <= '0;
                            r_rem  <= '0;
                            if (r_stp == STP_CANCEL_BOTH) begin
                                r_valid[r_best_idx] <= 1'b0;
                                r_state <= S_SECOND;
                            end else begin
                                r_state <= S_FINAL;
                            end
                        end
                    end else begin
                        o_kind           <= KIND_TRADE;
                        o_buy_order_id   <= buying ? r_id : r_best.order_id;
                        o_sell_order_id  <= buying ? r_best.order_id : r_id;
                        o_trade_price    <= r_best.price;
                        o_trade_quantity <= fill;
                        o_remaining_quantity <= rem_after;
                        r_rem <= rem_after;
                        if (newq == '0) begin
                            r_valid[r_best_idx] <= 1'b0;
                        end
                        if (rem_after == '0) begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                S_SECOND: begin
                    // resting half of a cancel-both
                    o_strobe <= 1'b1;
                    o_kind   <= KIND_RESTING;
                    o_cancelled_order_id <= r_best.order_id;
                    o_remaining_quantity <= '0;
                    r_state  <= S_FINAL;
                end
                S_FINAL: begin
                    o_strobe             <= 1'b1;
                    o_kind               <= KIND_FINAL;
                    o_buy_order_id       <= '0;
                    o_sell_order_id      <= '0;
                    o_trade_price        <= '0;
                    o_trade_quantity     <= '0;
                    o_cancelled_order_id <= '0;
                    o_status             <= ST_OK;
                    o_remaining_quantity <= r_rem;
                    o_last               <= 1'b1;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> hdl/obm_ram.sv
// generic single write port ram with registered read
module obm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/obm_checker.sv
// port-level checks for the order book matcher
module obm_checker
    import obm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_kind,
    input logic [31:0] o_trade_quantity,
    input logic        o_last
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final result shown while still busy");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last != (o_kind == KIND_FINAL) |-> 1'b0)
        else $error("last flag does not match final kind");

    a_trade_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind == KIND_TRADE |-> o_trade_quantity != '0)
        else $error("trade with zero quantity");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("reset did not idle the block");
endmodule

bind order_book_matcher obm_checker u_obm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_strobe         (o_strobe),
    .o_kind           (o_kind),
    .o_trade_quantity (o_trade_quantity),
    .o_last           (o_last)
);

>>> dv/tb_order_book_matcher.sv
// self-checking testbench for the order book matcher
module tb_order_book_matcher;
    import obm_pkg::*;

    localparam int SLOTS = 32;

    typedef struct {
        logic        op;
        logic [31:0] id;
        logic        side;
        logic        otype;
        logic [1:0]  tif;
        logic [31:0] price;
        logic [31:0] qty;
        logic [15:0] trader;
        logic [2:0]  stp;
    } t_req;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] buy;
        logic [31:0] sell;
        logic [31:0] px;
        logic [31:0] qty;
        logic [31:0] canc;
        logic [3:0]  status;
        logic [31:0] rem;
        logic        last;
    } t_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = OP_ADD;
    logic [31:0] i_order_id = '0;
    logic        i_side = SIDE_BUY;
    logic        i_order_type = TYPE_LIMIT;
    logic [1:0]  i_time_in_force = TIF_GTC;
    logic [31:0] i_price = '0;
    logic [31:0] i_quantity = '0;
    logic [15:0] i_trader_id = '0;
    logic [2:0]  i_stp_mode = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [31:0] o_buy_order_id;
    logic [31:0] o_sell_order_id;
    logic [31:0] o_trade_price;
    logic [31:0] o_trade_quantity;
    logic [31:0] o_cancelled_order_id;
    logic [3:0]  o_status;
    logic [31:0] o_remaining_quantity;
    logic        o_last;

    // shadow copy of the book used for prediction
    bit          bk_valid [SLOTS];
    logic [31:0] bk_id    [SLOTS];
    logic        bk_side  [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [31:0] bk_qty   [SLOTS];
    logic [15:0] bk_trader[SLOTS];
    logic [31:0] bk_arr   [SLOTS];
    logic [31:0] bk_ctr = '0;

    t_fill pending_fills[$];
    int    n_errors = 0;
    int    n_results = 0;
    int    n_requests = 0;
    int    n_trades = 0;

    always #4 i_clk = ~i_clk;

    order_book_matcher #(.ORDER_SLOTS(SLOTS)) i_dut (.*);

    function automatic void push_fill(logic [1:0] kind, logic [31:0] buy, logic [31:0] sell,
                                      logic [31:0] px, logic [31:0] qty, logic [31:0] canc,
                                      logic [3:0] st, logic [31:0] rem, logic last);
        t_fill f;
        f = '{kind, buy, sell, px, qty, canc, st, rem, last};
        pending_fills = {pending_fills, f};
    endfunction

    function automatic bit px_ok(bit buying, logic [31:0] px, logic [31:0] lim);
        return buying ? (px <= lim) : (px >= lim);
    endfunction

    // expected results of one accepted request, updates the shadow book
    function automatic void predict_book(t_req r);
        bit          buying, stp_on, found, any, own, best_own, better;
        logic [3:0]  st;
        logic [31:0] rem, fill, rid;
        longint unsigned avail;
        int          best, free_slot;
        buying = (r.side == SIDE_BUY);
        stp_on = (r.trader != 0) && r.stp >= STP_CANCEL_NEW && r.stp <= STP_SKIP_OWN;
        st = ST_OK;
        if (r.op == OP_CANCEL) begin
            found = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && bk_valid[i] && bk_id[i] == r.id) begin
                    bk_valid[i] = 0;
                    found = 1;
                end
            end
            push_fill(KIND_FINAL, 0, 0, 0, 0, 0, found ? ST_OK : ST_NOT_FOUND, 0, 1'b1);
            return;
        end
        for (int i = 0; i < SLOTS; i++)
            if (bk_valid[i] && bk_id[i] == r.id) st = ST_DUPLICATE;
        if (st == ST_OK && r.qty == 0) st = ST_ZERO_QTY;
        if (st == ST_OK && r.otype == TYPE_LIMIT && r.price == 0) st = ST_NO_PRICE;
        if (st == ST_OK && r.otype == TYPE_MARKET && r.tif == TIF_GTC) st = ST_MKT_GTC;
        if (st == ST_OK && r.tif == TIF_FOK) begin
            avail = 0;
            for (int i = 0; i < SLOTS; i++)
                if (bk_valid[i] && bk_side[i] != r.side &&
                    (r.price == 0 || px_ok(buying, bk_price[i], r.price)))
                    avail += bk_qty[i];
            if (avail < r.qty) st = ST_FOK_SHORT;
        end
        if (st == ST_OK && r.otype == TYPE_MARKET) begin
            any = 0;
            for (int i = 0; i < SLOTS; i++)
                if (bk_valid[i] && bk_side[i] != r.side) any = 1;
            if (!any) st = ST_NO_LIQ;
        end
        if (st != ST_OK) begin
            push_fill(KIND_FINAL, 0, 0, 0, 0, 0, st, r.qty, 1'b1);
            return;
        end
        rem = r.qty;
        while (rem > 0) begin
            best = -1;
            best_own = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!bk_valid[i] || bk_side[i] == r.side) continue;
                if (r.otype == TYPE_LIMIT && !px_ok(buying, bk_price[i], r.price)) continue;
                own = stp_on && bk_trader[i] == r.trader;
                if (own && r.stp == STP_SKIP_OWN) continue;
                if (best < 0) begin
                    best = i;
                    best_own = own;
                end else begin
                    better = buying ? (bk_price[i] < bk_price[best])
                                    : (bk_price[i] > bk_price[best]);
                    // wrap-safe age: bigger distance from the counter is older
                    if (bk_price[i] == bk_price[best] &&
                        32'(bk_ctr - bk_arr[i]) > 32'(bk_ctr - bk_arr[best]))
                        better = 1;
                    if (better) begin
                        best = i;
                        best_own = own;
                    end
                end
            end
            if (best < 0) break;
            if (best_own) begin
                if (r.stp == STP_CANCEL_NEW) begin
                    rem = 0;
                    push_fill(KIND_INCOMING, 0, 0, 0, 0, r.id, ST_OK, 0, 1'b0);
                end else if (r.stp == STP_CANCEL_OLD) begin
                    bk_valid[best] = 0;
                    push_fill(KIND_RESTING, 0, 0, 0, 0, bk_id[best], ST_OK, rem, 1'b0);
                end else begin
                    rem = 0;
                    bk_valid[best] = 0;
                    push_fill(KIND_INCOMING, 0, 0, 0, 0, r.id, ST_OK, 0, 1'b0);
                    push_fill(KIND_RESTING, 0, 0, 0, 0, bk_id[best], ST_OK, 0, 1'b0);
                end
            end else begin
                fill = (rem < bk_qty[best]) ? rem : bk_qty[best];
                rid = bk_id[best];
                rem -= fill;
                bk_qty[best] -= fill;
                if (bk_qty[best] == 0) bk_valid[best] = 0;
                push_fill(KIND_TRADE, buying ? r.id : rid, buying ? rid : r.id,
                          bk_price[best], fill, 0, ST_OK, rem, 1'b0);
            end
        end
        if (rem > 0 && r.otype == TYPE_LIMIT && r.tif == TIF_GTC) begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!bk_valid[i]) free_slot = i;
            if (free_slot < 0) begin
                st = ST_FULL;
            end else begin
                bk_valid[free_slot]  = 1;
                bk_id[free_slot]     = r.id;
                bk_side[free_slot]   = r.side;
                bk_price[free_slot]  = r.price;
                bk_qty[free_slot]    = rem;
                bk_trader[free_slot] = r.trader;
                bk_arr[free_slot]    = bk_ctr;
                bk_ctr++;
            end
        end
        push_fill(KIND_FINAL, 0, 0, 0, 0, 0, st, rem, 1'b1);
    endfunction

    function automatic t_req mk(logic op, logic [31:0] id, logic side, logic otype,
                                logic [1:0] tif, logic [31:0] price, logic [31:0] qty,
                                logic [15:0] trader, logic [2:0] stp);
        t_req r;
        r = '{op, id, side, otype, tif, price, qty, trader, stp};
        return r;
    endfunction

    // drive one request and hold it until the block takes the transfer
    task automatic send(t_req r);
        @(negedge i_clk);
        start           <= 1'b1;
        i_operation     <= r.op;
        i_order_id      <= r.id;
        i_side          <= r.side;
        i_order_type    <= r.otype;
        i_time_in_force <= r.tif;
        i_price         <= r.price;
        i_quantity      <= r.qty;
        i_trader_id     <= r.trader;
        i_stp_mode      <= r.stp;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_book(r);
        n_requests++;
    endtask

    task automatic pause(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        pause(1);
        wait (pending_fills.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // compare each result against the oldest prediction
    always @(posedge i_clk) begin
        t_fill e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (pending_fills.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0d",
                         $time, o_kind);
                n_errors++;
            end else begin
                e = pending_fills.pop_front();
                if (e.kind == KIND_TRADE) n_trades++;
                check_field("kind", e.kind, o_kind);
                check_field("buy_order_id", e.buy, o_buy_order_id);
                check_field("sell_order_id", e.sell, o_sell_order_id);
                check_field("trade_price", e.px, o_trade_price);
                check_field("trade_quantity", e.qty, o_trade_quantity);
                check_field("cancelled_order_id", e.canc, o_cancelled_order_id);
                check_field("status", e.status, o_status);
                check_field("remaining_quantity", e.rem, o_remaining_quantity);
                check_field("last", e.last, o_last);
            end
        end
    end

    // each validation reject, in checking order, plus cancel hit and miss
    task automatic test_rejects();
        send(mk(OP_ADD, 32'd1, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd100, 32'd5, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd1, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd90, 32'd5, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd2, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd90, 32'd0, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd3, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd0, 32'd5, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd4, 1'b0, TYPE_MARKET, TIF_GTC, 32'd0, 32'd5, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd5, 1'b0, TYPE_LIMIT, TIF_FOK, 32'd100, 32'd6, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd6, 1'b1, TYPE_MARKET, 2'd1, 32'd0, 32'd5, 16'd0, 3'd0));
        send(mk(OP_CANCEL, 32'd77, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd0, 32'd0, 16'd0, 3'd0));
        send(mk(OP_CANCEL, 32'd1, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd0, 32'd0, 16'd0, 3'd0));
        drain();
    endtask

    // price then time priority, partial fills, fok success, tif 3 as ioc, extremes
    task automatic test_matching();
        send(mk(OP_ADD, 32'd10, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd101, 32'd4, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd11, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd100, 32'd3, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd12, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd100, 32'd3, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd13, 1'b0, TYPE_LIMIT, TIF_FOK, 32'd100, 32'd6, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd14, 1'b0, TYPE_LIMIT, 2'd3, 32'd102, 32'd9, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'hFFFF_FFFF, 1'b1, TYPE_LIMIT, TIF_GTC, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 16'hFFFF, 3'd7));
        send(mk(OP_ADD, 32'd15, 1'b0, TYPE_MARKET, TIF_FOK, 32'd0, 32'hFFFF_FFFF,
                16'd0, 3'd0));
        send(mk(OP_ADD, 32'd16, 1'b0, TYPE_MARKET, 2'd1, 32'd0, 32'hFFFF_FFFF, 16'h8000, 3'd5));
        drain();
    endtask

    // self-trade prevention in every mode, and an unused mode acting as allow
    task automatic test_self_trade();
        send(mk(OP_ADD, 32'd20, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd50, 32'd2, 16'd7, 3'd0));
        send(mk(OP_ADD, 32'd21, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd51, 32'd2, 16'd8, 3'd0));
        send(mk(OP_ADD, 32'd22, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd60, 32'd3, 16'd7, STP_SKIP_OWN));
        send(mk(OP_ADD, 32'd23, 1'b0, TYPE_LIMIT, 2'd1, 32'd60, 32'd3, 16'd7, STP_CANCEL_NEW));
        send(mk(OP_ADD, 32'd24, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd52, 32'd2, 16'd7, 3'd0));
        send(mk(OP_ADD, 32'd25, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd53, 32'd2, 16'd9, 3'd0));
        send(mk(OP_ADD, 32'd26, 1'b0, TYPE_LIMIT, 2'd1, 32'd60, 32'd3, 16'd7, STP_CANCEL_OLD));
        send(mk(OP_ADD, 32'd27, 1'b1, TYPE_LIMIT, TIF_GTC, 32'd54, 32'd2, 16'd7, 3'd0));
        send(mk(OP_ADD, 32'd28, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd60, 32'd3, 16'd7,
                STP_CANCEL_BOTH));
        send(mk(OP_ADD, 32'd29, 1'b0, TYPE_MARKET, 2'd1, 32'd0, 32'd9, 16'd7, 3'd6));
        drain();
    endtask

    // fill every slot, overflow it, then sweep the whole book in one request
    task automatic test_book_full();
        for (int i = 0; i < SLOTS; i++)
            send(mk(OP_ADD, 32'd1000 + i, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd10 + i % 3,
                    32'd1 + i % 4, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd2000, 1'b0, TYPE_LIMIT, TIF_GTC, 32'd9, 32'd1, 16'd0, 3'd0));
        send(mk(OP_ADD, 32'd2001, 1'b1, TYPE_MARKET, 2'd1, 32'd0, 32'd500, 16'd0, 3'd0));
        drain();
    endtask

    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.op     = (pick < 20) ? OP_CANCEL : OP_ADD;
        r.id     = $urandom_range(1, 40);
        r.side   = 1'($urandom_range(0, 1));
        r.otype  = ($urandom_range(0, 99) < 15) ? TYPE_MARKET : TYPE_LIMIT;
        r.tif    = ($urandom_range(0, 99) < 60) ? TIF_GTC : 2'($urandom_range(1, 3));
        r.price  = ($urandom_range(0, 49) == 0) ? 32'd0 : 32'($urandom_range(95, 105));
        r.qty    = ($urandom_range(0, 49) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
        r.trader = 16'($urandom_range(0, 3));
        r.stp    = 3'($urandom_range(0, 7));
        // occasional raw noise so every field bit toggles
        if (pick >= 95) begin
            r.id     = $urandom();
            r.price  = $urandom();
            r.qty    = $urandom();
            r.trader = 16'($urandom());
            r.tif    = 2'($urandom());
        end
        return r;
    endfunction

    // random traffic sent in bursts with random gaps
    task automatic test_random();
        int burst;
        burst = 0;
        for (int n = 0; n < 100; n++) begin
            send(random_req());
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 60));
            end
            burst--;
            if (n == 50) drain();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_rejects();
        test_matching();
        test_self_trade();
        test_book_full();
        test_random();
        drain();
        repeat (200) @(negedge i_clk);
        $display("covered %0d requests, %0d results, %0d trades", n_requests, n_results,
                 n_trades);
        $display("rejects, price-time matching, all stp modes, full book, random bursts");
        if (n_errors == 0 && pending_fills.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #40000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
hdl/obm_pkg.sv
hdl/obm_ram.sv
hdl/order_book_matcher.sv
hdl/obm_checker.sv
dv/tb_order_book_matcher.sv
